/* sv/fpwf_pkg.sv */
// Package for the fixed-partition worst-fit allocator.
// Holds sizes, codes, entry and result types shared across the modules.
`default_nettype none
package fpwf_pkg;

    localparam int PARTITIONS = 8;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W      = $clog2(PARTITIONS + 1);
    localparam int SUM_W      = SIZE_BITS + CNT_W;
    localparam int STATUS_W   = 4;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 104;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_REPORT = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 4'd0,
        ST_NO_FREE      = 4'd1,
        ST_TOO_LARGE    = 4'd2,
        ST_INSUFFICIENT = 4'd3,
        ST_INT_FRAG     = 4'd4,
        ST_EXT_FRAG     = 4'd5,
        ST_NOT_FOUND    = 4'd6,
        ST_ZEROED       = 4'd7,
        ST_TABLE_FULL   = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] used;
        logic                 busy;
        logic [15:0]          owner;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] used;
        logic [15:0]          owner;
        logic                 valid;
        logic [SIZE_BITS-1:0] frag;
        logic [SIZE_BITS-1:0] unused;
        logic [SIZE_BITS-1:0] net;
        logic                 last;
    } result_t;

endpackage
`default_nettype wire

/* sv/fixed_partition_worst_fit_allocator.sv */
// Top level of the fixed-partition worst-fit allocator.
// Instantiates fpwf_ram and fpwf_ctrl; depends on fpwf_pkg.
//
//  channel | direction | handshake            | payload
//  s_*     | in        | s_tvalid / s_tready  | s_tuser mode, s_tdata request, id
//  m_*     | out       | m_tvalid / m_tready  | m_tuser status, m_tdata row, m_tlast
//  cfg_*   | in        | cfg_wr_en            | cfg_wr_data total memory size
//
// Add records one partition; insert, delete and report read every partition in turn
// through the one-entry-per-cycle read port of the partition memory, whose read is
// registered; a report scan halts while its row waits for the output.
// Each output word waits while the output register holds a word not yet taken.
// Reset leaves no partitions and all memory unassigned; a register write does the same.
// One item is worked at a time; a new word is taken while the last result waits.
`default_nettype none
module fixed_partition_worst_fit_allocator (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // mode
    input  wire logic [31:0]  s_tdata,   // request_size[15:0], pid[31:16]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [3:0]        m_tuser,   // status
    // partition_index[2:0], partition_size[18:3], used_size[34:19], owner_pid[50:35],
    // owner_valid[51], frag[67:52], unused_space[83:68],
    // net_internal_frag[99:84], zero[103:100]
    output logic [103:0]      m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data
);

    fpwf_pkg::ram_req_t ram_req;
    fpwf_pkg::entry_t   ram_rdata;
    fpwf_pkg::result_t  res;

    fpwf_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    fpwf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_req    (s_tdata[15:0]),
        .in_pid    (s_tdata[31:16]),
        .cfg_we    (cfg_wr_en),
        .cfg_data  (cfg_wr_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result word
    assign m_tuser = res.status;
    assign m_tlast = res.last;
    assign m_tdata = {4'd0, res.net, res.unused, res.frag, res.valid,
                      res.owner, res.used, res.size, res.idx};

endmodule
`default_nettype wire

/* sv/fpwf_ram.sv */
// Partition table memory: one write port, one read port, registered read.
// Depends on fpwf_pkg for the entry type.
`default_nettype none
module fpwf_ram (
    input  wire logic                clk,
    input  wire fpwf_pkg::ram_req_t  req,
    output fpwf_pkg::entry_t         rdata
);

    fpwf_pkg::entry_t mem [fpwf_pkg::PARTITIONS];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read; hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/fpwf_ctrl.sv */
// Allocator sequencer: scans the partition memory, decides, writes back,
// and holds the result word register. Depends on fpwf_pkg.
`default_nettype none
module fpwf_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     in_mode,
    input  wire logic [fpwf_pkg::SIZE_BITS-1:0] in_req,
    input  wire logic [15:0]                    in_pid,
    input  wire logic                           cfg_we,
    input  wire logic [15:0]                    cfg_data,
    output fpwf_pkg::ram_req_t                  ram_req,
    input  wire fpwf_pkg::entry_t               ram_rdata,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output fpwf_pkg::result_t                   out_res
);

    localparam int SB = fpwf_pkg::SIZE_BITS;
    localparam int IW = fpwf_pkg::IDX_W;
    localparam int CW = fpwf_pkg::CNT_W;
    localparam int UW = fpwf_pkg::SUM_W;

    fpwf_pkg::state_t state_reg, state_next;
    fpwf_pkg::mode_t  mode_reg, mode_next;
    logic [SB-1:0] req_reg, req_next;
    logic [15:0]   pid_reg, pid_next;
    logic [15:0]   id_reg, id_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SB-1:0] space_reg, space_next;
    logic [SB-1:0] largest_reg, largest_next;
    logic [15:0]   next_pid_reg, next_pid_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          dv_reg, dv_next;
    logic [IW-1:0] didx_reg, didx_next;
    logic          found_reg, found_next;
    logic [IW-1:0] best_reg, best_next;
    logic [SB-1:0] best_size_reg, best_size_next;
    logic          fit_reg, fit_next;
    logic [UW-1:0] sum_reg, sum_next;
    logic [UW-1:0] net_reg, net_next;
    logic          ov_reg, ov_next;
    fpwf_pkg::result_t res_reg, res_next;

    logic              out_free;
    logic              stall;
    logic              issue_more;
    logic              out_load;
    fpwf_pkg::result_t res_new;
    logic [SB-1:0]     ent_free;
    logic [SB-1:0]     rec_size;

    function automatic fpwf_pkg::result_t describe(fpwf_pkg::entry_t e, logic [IW-1:0] i);
        fpwf_pkg::result_t r;
        r        = '0;
        r.status = fpwf_pkg::ST_OK;
        r.idx    = i;
        r.size   = e.size;
        r.used   = e.used;
        r.valid  = e.busy;
        r.owner  = e.busy ? e.owner : 16'd0;
        r.frag   = e.busy ? (e.size - e.used) : '0;
        return r;
    endfunction

    assign out_free   = !ov_reg || out_ready;
    assign issue_more = issue_reg < count_reg;
    assign ent_free   = ram_rdata.size - ram_rdata.used;
    assign stall      = (state_reg == fpwf_pkg::S_SCAN) && dv_reg
                        && (mode_reg == fpwf_pkg::MODE_REPORT)
                        && (ram_rdata.size != '0) && !out_free;
    assign rec_size   = (req_reg > space_reg) ? '0 : req_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpwf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (fpwf_pkg::mode_t'(in_mode) == fpwf_pkg::MODE_ADD)
                                 ? fpwf_pkg::S_ADD : fpwf_pkg::S_SCAN;
                end
            end
            fpwf_pkg::S_ADD:
            begin
                if (out_free)
                begin
                    state_next = fpwf_pkg::S_IDLE;
                end
            end
            fpwf_pkg::S_SCAN:
            begin
                if (!issue_more && !dv_reg)
                begin
                    state_next = fpwf_pkg::S_FINISH;
                end
            end
            fpwf_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = fpwf_pkg::S_IDLE;
                end
            end
            default: state_next = fpwf_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory access and result words
    always_comb
    begin
        in_ready       = (state_reg == fpwf_pkg::S_IDLE);
        mode_next      = mode_reg;
        req_next       = req_reg;
        pid_next       = pid_reg;
        id_next        = id_reg;
        count_next     = count_reg;
        space_next     = space_reg;
        largest_next   = largest_reg;
        next_pid_next  = next_pid_reg;
        issue_next     = issue_reg;
        dv_next        = dv_reg;
        didx_next      = didx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_size_next = best_size_reg;
        fit_next       = fit_reg;
        sum_next       = sum_reg;
        net_next       = net_reg;
        ram_req        = '0;
        out_load       = 1'b0;
        res_new        = '0;
        res_new.status = fpwf_pkg::ST_OK;
        res_new.unused = space_reg;
        res_new.last   = 1'b1;

        unique case (state_reg)
            fpwf_pkg::S_IDLE:
            begin
                // Latch the item and clear the scan state
                if (in_valid)
                begin
                    mode_next  = fpwf_pkg::mode_t'(in_mode);
                    req_next   = in_req;
                    pid_next   = in_pid;
                    issue_next = '0;
                    dv_next    = 1'b0;
                    found_next = 1'b0;
                    best_next  = '0;
                    best_size_next = '0;
                    fit_next   = 1'b0;
                    sum_next   = '0;
                    net_next   = '0;
                    if (fpwf_pkg::mode_t'(in_mode) == fpwf_pkg::MODE_INSERT)
                    begin
                        id_next       = next_pid_reg;
                        next_pid_next = next_pid_reg + 16'd1;
                    end
                end
            end
            fpwf_pkg::S_ADD:
            begin
                // Record the next partition
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (count_reg >= CW'(fpwf_pkg::PARTITIONS))
                    begin
                        res_new.status = fpwf_pkg::ST_TABLE_FULL;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = count_reg[IW-1:0];
                        ram_req.wdata = '{size: rec_size, used: '0, busy: 1'b0, owner: '0};
                        count_next    = count_reg + CW'(1);
                        space_next    = space_reg - rec_size;
                        if (rec_size > largest_reg)
                        begin
                            largest_next = rec_size;
                        end
                        res_new.status = (req_reg > space_reg) ? fpwf_pkg::ST_ZEROED
                                                               : fpwf_pkg::ST_OK;
                        res_new.idx    = count_reg[IW-1:0];
                        res_new.size   = rec_size;
                        res_new.unused = space_reg - rec_size;
                    end
                end
            end
            fpwf_pkg::S_SCAN:
            begin
                if (!stall)
                begin
                    // Advance the read pointer
                    ram_req.re    = issue_more;
                    ram_req.raddr = issue_reg[IW-1:0];
                    issue_next    = issue_reg + (issue_more ? CW'(1) : CW'(0));
                    dv_next       = issue_more;
                    didx_next     = issue_reg[IW-1:0];
                    // Evaluate the entry returned by the registered read
                    if (dv_reg)
                    begin
                        case (mode_reg)
                            fpwf_pkg::MODE_INSERT:
                            begin
                                if (!ram_rdata.busy &&
                                    (!found_reg || ram_rdata.size > best_size_reg))
                                begin
                                    found_next     = 1'b1;
                                    best_next      = didx_reg;
                                    best_size_next = ram_rdata.size;
                                end
                                if (!fit_reg)
                                begin
                                    sum_next = sum_reg + UW'(ent_free);
                                    if (ent_free >= req_reg)
                                    begin
                                        fit_next = 1'b1;
                                    end
                                end
                            end
                            fpwf_pkg::MODE_DELETE:
                            begin
                                if (!found_reg && ram_rdata.busy && ram_rdata.owner == pid_reg)
                                begin
                                    found_next     = 1'b1;
                                    best_next      = didx_reg;
                                    best_size_next = ram_rdata.size;
                                end
                            end
                            fpwf_pkg::MODE_REPORT:
                            begin
                                if (ram_rdata.size != '0)
                                begin
                                    out_load       = 1'b1;
                                    res_new        = describe(ram_rdata, didx_reg);
                                    res_new.unused = space_reg;
                                    res_new.last   = 1'b0;
                                    if (ram_rdata.busy)
                                    begin
                                        net_next = net_reg + UW'(ent_free);
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            fpwf_pkg::S_FINISH:
            begin
                // Write back an insert or delete and give the final word
                if (out_free)
                begin
                    out_load = 1'b1;
                    case (mode_reg)
                        fpwf_pkg::MODE_INSERT:
                        begin
                            res_new.owner = id_reg;
                            if (!found_reg || best_size_reg == '0)
                            begin
                                res_new.status = fpwf_pkg::ST_NO_FREE;
                            end
                            else if (req_reg > best_size_reg)
                            begin
                                if (req_reg > largest_reg)
                                begin
                                    res_new.status = fpwf_pkg::ST_TOO_LARGE;
                                end
                                else if (UW'(req_reg) > sum_reg)
                                begin
                                    res_new.status = fpwf_pkg::ST_INSUFFICIENT;
                                end
                                else if (fit_reg)
                                begin
                                    res_new.status = fpwf_pkg::ST_INT_FRAG;
                                end
                                else
                                begin
                                    res_new.status = fpwf_pkg::ST_EXT_FRAG;
                                end
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = best_reg;
                                ram_req.wdata = '{size: best_size_reg, used: req_reg,
                                                  busy: 1'b1, owner: id_reg};
                                res_new.idx   = best_reg;
                                res_new.size  = best_size_reg;
                                res_new.used  = req_reg;
                                res_new.valid = 1'b1;
                                res_new.frag  = best_size_reg - req_reg;
                            end
                        end
                        fpwf_pkg::MODE_DELETE:
                        begin
                            res_new.owner = pid_reg;
                            if (found_reg)
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = best_reg;
                                ram_req.wdata = '{size: best_size_reg, used: '0,
                                                  busy: 1'b0, owner: '0};
                                res_new.idx   = best_reg;
                                res_new.size  = best_size_reg;
                            end
                            else
                            begin
                                res_new.status = fpwf_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            // Summary word, net fragment saturates
                            res_new.net = (net_reg > UW'({SB{1'b1}})) ? {SB{1'b1}}
                                                                       : net_reg[SB-1:0];
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        // Register write restarts the allocator
        if (cfg_we)
        begin
            count_next    = '0;
            space_next    = cfg_data[SB-1:0];
            largest_next  = '0;
            next_pid_next = '0;
        end
    end

    assign ov_next  = out_load ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    assign res_next = out_load ? res_new : res_reg;

    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fpwf_pkg::S_IDLE;
            count_reg    <= '0;
            space_reg    <= {SB{1'b1}};
            largest_reg  <= '0;
            next_pid_reg <= '0;
            dv_reg       <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            space_reg    <= space_next;
            largest_reg  <= largest_next;
            next_pid_reg <= next_pid_next;
            dv_reg       <= dv_next;
            ov_reg       <= ov_next;
        end
    end

    // Item and scan payload
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        req_reg       <= req_next;
        pid_reg       <= pid_next;
        id_reg        <= id_next;
        issue_reg     <= issue_next;
        didx_reg      <= didx_next;
        found_reg     <= found_next;
        best_reg      <= best_next;
        best_size_reg <= best_size_next;
        fit_reg       <= fit_next;
        sum_reg       <= sum_next;
        net_reg       <= net_next;
        res_reg       <= res_next;
    end

endmodule
`default_nettype wire

/* sv/fpwf_checker.sv */
// Port-level checks for the allocator, bound to the top level.
// Depends on fpwf_pkg for status codes.
`default_nettype none
module fpwf_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [3:0]   m_tuser,
    input wire logic [103:0] m_tdata,
    input wire logic         m_tlast
);

    // Hold a stalled word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

    // A failed request never shows an owned partition
    a_fail_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != fpwf_pkg::ST_OK) |-> !m_tdata[51])
        else $error("failed request shows an owner");

    // Net fragment only in the closing summary
    a_net_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[99:84] == 16'd0))
        else $error("net fragment outside summary");

    // Report rows are always ok
    a_row_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tuser == fpwf_pkg::ST_OK))
        else $error("report row with error status");

endmodule

bind fixed_partition_worst_fit_allocator fpwf_checker u_fpwf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
